// ----- rtl/led_bpc_pkg.sv -----
package led_bpc_pkg;

  // Interval timer width; any value from 8 to 32 works.
  localparam int TimerWidth = 16;

  localparam int ModeWidth   = 3;
  localparam int CountWidth  = 9;
  localparam int GroupWidth  = 8;
  localparam int PeriodWidth = 16;
  localparam int NumberWidth = 15;
  localparam int CfgIdxWidth = 2;
  localparam int InTdataWidth  = 16;
  localparam int OutTdataWidth = 8;

  // Width used to compare a raw interval against the timer range.
  localparam int LimWidth = (TimerWidth > NumberWidth + 2) ? TimerWidth : NumberWidth + 2;

  localparam logic [ModeWidth-1:0] ModeOff    = 3'd0;
  localparam logic [ModeWidth-1:0] ModeOn     = 3'd1;
  localparam logic [ModeWidth-1:0] ModeSlow   = 3'd2;
  localparam logic [ModeWidth-1:0] ModeQuick  = 3'd3;
  localparam logic [ModeWidth-1:0] ModeNumber = 3'd4;

  localparam logic KindTick    = 1'b0;
  localparam logic KindCommand = 1'b1;

  localparam logic [CfgIdxWidth-1:0] CfgSlowPeriod   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgQuickPeriod  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgNumberPeriod = 2'd2;

  localparam logic [PeriodWidth-1:0] SlowPeriodReset   = 16'd500;
  localparam logic [PeriodWidth-1:0] QuickPeriodReset  = 16'd100;
  localparam logic [NumberWidth-1:0] NumberPeriodReset = 15'd200;

  typedef struct packed {
    logic [ModeWidth-1:0]  mode;
    logic                  led;
    logic [TimerWidth-1:0] ticks;
    logic [CountWidth-1:0] count;
    logic [GroupWidth-1:0] group;
  } led_state_t;

  typedef struct packed {
    logic                  kind;
    logic [ModeWidth-1:0]  mode;
    logic [GroupWidth-1:0] blink_total;
  } led_req_t;

  typedef struct packed {
    logic [PeriodWidth-1:0] slow_period;
    logic [PeriodWidth-1:0] quick_period;
    logic [NumberWidth-1:0] number_period;
  } led_cfg_t;

  // Saturate a raw interval to the timer range.
  function automatic logic [TimerWidth-1:0] timer_limit(logic [NumberWidth+1:0] v);
    logic [LimWidth-1:0] wide;
    logic [LimWidth-1:0] top;
    wide = LimWidth'(v);
    top  = LimWidth'({TimerWidth{1'b1}});
    return (wide > top) ? {TimerWidth{1'b1}} : wide[TimerWidth-1:0];
  endfunction

endpackage

// ----- rtl/led_blink_pattern_controller_top.sv -----
// LED blink pattern controller.
// Input stream: each request is a time tick (s_axis_tuser = 0) or a mode
// command (s_axis_tuser = 1) carrying the mode and, for blink-number, the
// number of blinks per group. Every request yields exactly one result on the
// output stream: the LED level and the active mode after that request.
// Configuration channel: cfg_valid_i/cfg_ready_o with a register index
// (0 slow period, 1 quick period, 2 number period) and 16-bit data; writes
// are always taken and other indexes are dropped. Write only while idle.
// Results are registered in the output register, or in the skid register
// while the receiver stalls. Throughput: one request per cycle while the
// skid register is empty; the whole update of the mode, LED, interval timer
// and toggle count is one pass of logic between state and result registers.
// Stall: an output register plus one skid register hold results while the
// receiver stalls; s_axis_tready drops only once the skid holds a result.
// Reset: mode off, LED dark, timer and counts cleared, periods back to
// 500, 100 and 200 ticks, both result registers empty.
module led_blink_pattern_controller_top import led_bpc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [2:0] mode, [10:3] blink_total, [15:11] zero
  input  logic [InTdataWidth-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] led_level, [3:1] active_mode, [7:4] zero
  output logic [OutTdataWidth-1:0] m_axis_tdata,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [PeriodWidth-1:0]   cfg_data_i
);

  led_cfg_t   cfg_q;
  led_state_t state_q;
  led_state_t state_d;
  led_req_t   req;

  logic                     accept;
  logic                     out_valid_q;
  logic                     out_valid_d;
  logic [OutTdataWidth-1:0] out_data_q;
  logic [OutTdataWidth-1:0] out_data_d;
  logic                     skid_valid_q;
  logic                     skid_valid_d;
  logic [OutTdataWidth-1:0] skid_data_q;
  logic [OutTdataWidth-1:0] skid_data_d;
  logic [OutTdataWidth-1:0] result;

  assign req.kind        = s_axis_tuser;
  assign req.mode        = s_axis_tdata[2:0];
  assign req.blink_total = s_axis_tdata[10:3];

  // Hold off new requests only while the skid slot is occupied.
  assign s_axis_tready = ~skid_valid_q;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_period   <= SlowPeriodReset;
      cfg_q.quick_period  <= QuickPeriodReset;
      cfg_q.number_period <= NumberPeriodReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSlowPeriod:   cfg_q.slow_period   <= cfg_data_i;
        CfgQuickPeriod:  cfg_q.quick_period  <= cfg_data_i;
        CfgNumberPeriod: cfg_q.number_period <= cfg_data_i[NumberWidth-1:0];
        default: ;
      endcase
    end
  end

  led_bpc_step u_step (
    .state_i (state_q),
    .req_i   (req),
    .cfg_i   (cfg_q),
    .state_o (state_d)
  );

  // Advance the controller state on every accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  assign result = OutTdataWidth'({state_d.mode, state_d.led});

  // Output register with one skid slot behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || m_axis_tready) begin
      // Output slot frees up: drain the skid first, else take the new result.
      out_valid_d  = skid_valid_q | accept;
      out_data_d   = skid_valid_q ? skid_data_q : result;
      skid_valid_d = 1'b0;
    end else if (accept) begin
      // Receiver stalls: park the new result in the skid slot.
      skid_valid_d = 1'b1;
      skid_data_d  = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a result while the output register is empty");

  a_stall_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("request accepted under stall was not parked");

  a_steady_no_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == ModeOff || state_q.mode == ModeOn) |-> (state_q.ticks == '0))
    else $error("interval timer loaded outside the blink modes");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:1] <= ModeNumber))
    else $error("result carries an undefined mode");
`endif

endmodule

// ----- rtl/led_bpc_step.sv -----
module led_bpc_step import led_bpc_pkg::*; (
  input  led_state_t state_i,
  input  led_req_t   req_i,
  input  led_cfg_t   cfg_i,
  output led_state_t state_o
);

  logic [TimerWidth-1:0] slow_ivl;
  logic [TimerWidth-1:0] quick_ivl;
  logic [TimerWidth-1:0] num_ivl;
  logic [TimerWidth-1:0] num_pause_ivl;
  logic [TimerWidth-1:0] tick_ivl;
  logic                  blinking;
  logic [CountWidth-1:0] count_inc;
  logic [CountWidth-1:0] count_wrap;

  assign slow_ivl      = timer_limit((NumberWidth+2)'(cfg_i.slow_period));
  assign quick_ivl     = timer_limit((NumberWidth+2)'(cfg_i.quick_period));
  assign num_ivl       = timer_limit((NumberWidth+2)'(cfg_i.number_period));
  assign num_pause_ivl = timer_limit({1'b0, cfg_i.number_period, 1'b0});

  assign blinking   = (state_i.mode == ModeSlow) || (state_i.mode == ModeQuick) ||
                      (state_i.mode == ModeNumber);
  assign count_inc  = state_i.count + CountWidth'(1);
  assign count_wrap = ({state_i.group, 1'b0} <= count_inc) ? '0 : count_inc;

  // Next interval as chosen from the mode and the count before it advances.
  always_comb begin
    case (state_i.mode)
      ModeSlow:  tick_ivl = slow_ivl;
      ModeQuick: tick_ivl = quick_ivl;
      default:   tick_ivl = (state_i.count == '0) ? num_pause_ivl : num_ivl;
    endcase
  end

  always_comb begin
    state_o = state_i;
    if (req_i.kind == KindCommand) begin
      case (req_i.mode) inside
        ModeOff, ModeOn: begin
          if (state_i.mode != req_i.mode) begin
            state_o.mode  = req_i.mode;
            state_o.led   = (req_i.mode == ModeOn);
            state_o.ticks = '0;
          end
        end
        ModeSlow, ModeQuick: begin
          if (state_i.mode != req_i.mode) begin
            state_o.mode  = req_i.mode;
            state_o.count = '0;
            state_o.led   = ~state_i.led;
            state_o.ticks = (req_i.mode == ModeSlow) ? slow_ivl : quick_ivl;
          end
        end
        ModeNumber: begin
          state_o.mode  = ModeNumber;
          state_o.group = req_i.blink_total;
          state_o.count = '0;
          state_o.led   = 1'b1;
          state_o.ticks = num_pause_ivl;
        end
        default: ;
      endcase
    end else if (blinking) begin
      if (state_i.ticks > TimerWidth'(1)) begin
        state_o.ticks = state_i.ticks - TimerWidth'(1);
      end else begin
        state_o.ticks = tick_ivl;
        state_o.led   = ~state_i.led;
        if (state_i.mode == ModeNumber) begin
          state_o.count = count_wrap;
        end
      end
    end
  end

endmodule
